// File: design/lkv_pkg.sv
package lkv_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } lkv_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lkv_sts_t;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic [31:0] READ_MISS   = 32'hFFFF_FFFF;
  localparam logic [4:0]  CAP_RESET   = 5'd16;

endpackage

// File: design/lkv_ctrl.sv
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  lkv_sts_t sts,
  output lkv_cmd_t cmd,
  output logic     busy
);

  lkv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: design/lkv_datapath.sv
module lkv_datapath
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lkv_cmd_t           cmd,
  output lkv_sts_t           sts,
  input  logic               in_func,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  input  logic               cfg_we,
  input  logic        [4:0]  cfg_capacity_in_use,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted,
  output logic signed [31:0] out_evicted_key
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int AGE_W = IDX_W;
  localparam int CAP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] val_mem [ENTRIES];

  logic [4:0]       cap_cfg_r;
  logic             func_r;
  logic [31:0]      key_r;
  logic [31:0]      wval_r;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [31:0]      key_rd_r;
  logic [31:0]      val_rd_r;
  logic             hit_r;
  logic [IDX_W-1:0] found_r;
  logic [31:0]      val_hit_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [IDX_W-1:0] lru_idx_r;
  logic [31:0]      lru_key_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [AGE_W-1:0] age_r [ENTRIES];
  logic [AGE_W-1:0] age_nxt [ENTRIES];
  logic [CNT_W-1:0] live_r, live_nxt;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [31:0]      out_read_value_r;
  logic             out_evicted_r;
  logic [31:0]      out_evicted_key_r;

  logic [CAP_W-1:0] cap_ext;
  logic [CAP_W-1:0] cap_clamp;
  logic             issue;
  logic [AGE_W-1:0] lru_age;
  logic             evict;
  logic             is_put;
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] old_age;
  logic             key_we;
  logic             val_we;

  // capacity clamp to 1 .. ENTRIES
  always_comb begin
    cap_ext = CAP_W'(cap_cfg_r);
    if (cap_ext == '0) begin
      cap_clamp = CAP_W'(1);
    end else if (cap_ext > CAP_W'(ENTRIES)) begin
      cap_clamp = CAP_W'(ENTRIES);
    end else begin
      cap_clamp = cap_ext;
    end
  end

  assign issue         = cmd.scan && (cnt_r < CNT_W'(ENTRIES));
  assign sts.scan_done = (cnt_r == CNT_W'(ENTRIES));
  assign lru_age       = AGE_W'(live_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_cfg_r <= cfg_capacity_in_use;
    end
  end

  // operand latch and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      cmp_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_lookup_key;
      wval_r <= in_write_value;
      cap_r  <= CNT_W'(cap_clamp);
    end
    if (issue) begin
      cmp_idx_r <= cnt_r[IDX_W-1:0];
    end
  end

  // tag and value store, one read and one write port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot] <= key_r;
    end
    if (val_we) begin
      val_mem[slot] <= wval_r;
    end
    if (issue) begin
      key_rd_r <= key_mem[cnt_r[IDX_W-1:0]];
      val_rd_r <= val_mem[cnt_r[IDX_W-1:0]];
    end
  end

  // per-entry compare during the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (valid_r[cmp_idx_r] && (key_rd_r == key_r) && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!valid_r[cmp_idx_r] && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (valid_r[cmp_idx_r] && (key_rd_r == key_r) && !hit_r) begin
        found_r   <= cmp_idx_r;
        val_hit_r <= val_rd_r;
      end
      if (!valid_r[cmp_idx_r] && !free_r) begin
        free_idx_r <= cmp_idx_r;
      end
      if (valid_r[cmp_idx_r] && (age_r[cmp_idx_r] == lru_age)) begin
        lru_idx_r <= cmp_idx_r;
        lru_key_r <= key_rd_r;
      end
    end
  end

  // recency and occupancy update
  assign is_put  = (func_r == FUNC_PUT);
  assign evict   = !hit_r && is_put && (live_r >= cap_r);
  assign slot    = hit_r ? found_r : (evict ? lru_idx_r : free_idx_r);
  assign old_age = age_r[found_r];
  assign key_we  = cmd.update && !hit_r && is_put;
  assign val_we  = cmd.update && is_put;

  always_comb begin
    valid_nxt = valid_r;
    live_nxt  = live_r;
    for (int j = 0; j < ENTRIES; j++) begin
      age_nxt[j] = age_r[j];
    end
    if (hit_r) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid_r[j] && (age_r[j] < old_age)) begin
          age_nxt[j] = age_r[j] + AGE_W'(1);
        end
      end
      age_nxt[found_r] = '0;
    end else if (is_put) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid_r[j] && !(evict && (IDX_W'(j) == lru_idx_r))) begin
          age_nxt[j] = age_r[j] + AGE_W'(1);
        end
      end
      valid_nxt[slot] = 1'b1;
      age_nxt[slot]   = '0;
      if (!evict) begin
        live_nxt = live_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r  <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        age_r[j] <= '0;
      end
    end else if (cmd.update) begin
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
      for (int j = 0; j < ENTRIES; j++) begin
        age_r[j] <= age_nxt[j];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r         <= hit_r;
      out_read_value_r  <= (hit_r && !is_put) ? val_hit_r : READ_MISS;
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? lru_key_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

// File: design/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement. An
// operation is taken when start is high and busy is low; it runs a tag search of
// one entry per cycle through the single read port of the key/value store, then
// an update state, and its result is registered. The result appears on the out_
// ports for exactly one cycle with out_valid high and cannot be stalled, so the
// receiver must take it then. Capacity writes on cfg_ are registered and sampled
// when an operation is taken, and should only be done while busy is low and no
// result is pending; a value of zero acts as one and values above ENTRIES act as
// ENTRIES.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_write_value,
  input  logic               cfg_we,
  input  logic        [4:0]  cfg_capacity_in_use,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted,
  output logic signed [31:0] out_evicted_key
);

  lkv_cmd_t cmd;
  lkv_sts_t sts;

  lkv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_lookup_key       (in_lookup_key),
    .in_write_value      (in_write_value),
    .cfg_we              (cfg_we),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .out_evicted         (out_evicted),
    .out_evicted_key     (out_evicted_key)
  );

endmodule
